FILE: sv/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the text console writer.
// Used by the cursor unit, the screen memory wrapper and the top level.
package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int CELL_W = 16;

	localparam logic [CHAR_W-1:0] PLAIN_ATTR = 8'h07;
	localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] CH_LF      = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'h0d;

	localparam logic KIND_PUT  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_COPY  = 5'b01000,
		ST_FILL  = 5'b10000
	} tcw_state_t;

	// Cursor update requests from the sequencer.
	typedef struct packed {
		logic advance;
		logic newline;
		logic to_bottom;
	} cur_cmd_t;

	// Cursor position flags seen by the sequencer.
	typedef struct packed {
		logic last_cell;
		logic bottom_row;
	} cur_stat_t;

endpackage

FILE: sv/tcw_screen_ram.sv
`timescale 1ns / 1ps
// Screen cell memory: one write port and one read port with registered read data.
// Depends on tcw_pkg for the cell width.
module tcw_screen_ram
	import tcw_pkg::*;
#(
	parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
	parameter int AW    = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// An address past the end comes from an out-of-range cell index or from the
	// copy sweep's last read; it returns zero.
	always_ff @(posedge clk) begin
		if (32'(raddr) < DEPTH) begin
			rdata_q <= mem[raddr];
		end else begin
			rdata_q <= '0;
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/tcw_cursor.sv
`timescale 1ns / 1ps
// Cursor unit: holds the cursor cell index with its column and row start,
// so that no division is needed for a newline. Depends on tcw_pkg.
module tcw_cursor
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS,
	parameter int AW      = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cur_cmd_t      cmd,
	output logic [AW-1:0] cursor,
	output cur_stat_t     stat
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int BOTTOM = CELLS - COLUMNS;
	localparam int CW     = $clog2(COLUMNS);

	logic [AW-1:0] cursor_q;
	logic [AW-1:0] row_base_q;
	logic [CW-1:0] col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q   <= '0;
			row_base_q <= '0;
			col_q      <= '0;
		end else if (cmd.to_bottom) begin
			cursor_q   <= AW'(BOTTOM);
			row_base_q <= AW'(BOTTOM);
			col_q      <= '0;
		end else if (cmd.newline) begin
			cursor_q   <= row_base_q + AW'(COLUMNS);
			row_base_q <= row_base_q + AW'(COLUMNS);
			col_q      <= '0;
		end else if (cmd.advance) begin
			cursor_q <= cursor_q + 1'b1;
			if (col_q == CW'(COLUMNS - 1)) begin
				col_q      <= '0;
				row_base_q <= row_base_q + AW'(COLUMNS);
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	assign cursor          = cursor_q;
	assign stat.last_cell  = (cursor_q == AW'(CELLS - 1));
	assign stat.bottom_row = (row_base_q == AW'(BOTTOM));

endmodule

FILE: sv/text_console_writer.sv
`timescale 1ns / 1ps
// Text console writer top level: command sequencer around the screen memory
// and the cursor unit. Depends on tcw_pkg, tcw_screen_ram and tcw_cursor.
//
// Usage:
//   A command is taken when start is high and busy is low. kind selects a put
//   (char_code) or a read of one cell (cell_index). Every command gives exactly
//   one result, shown for one cycle with done high: cell_char, cell_attr and the
//   cursor_position after the command. The receiver cannot stall; each result
//   transfer completes at the edge that ends its done cycle.
// Timing:
//   A put without scroll and an out-of-range read give done in the cycle after
//   the accepting edge, and busy stays low. An in-range read goes through
//   ST_READ for the synchronous memory read. A put that scrolls walks the memory
//   one cell per cycle through its single write port: a copy pass moves each
//   row up by one, then a fill pass writes NUL characters to the bottom row,
//   and done follows the last fill write.
// Reset:
//   arst_n clears the cursor and starts a clearing pass that writes zero to all
//   ROWS*COLUMNS cells, one per cycle; busy is high throughout that pass.
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              kind,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [IDX_W-1:0]  cell_index,
	output logic              done,
	output logic [CHAR_W-1:0] cell_char,
	output logic [CHAR_W-1:0] cell_attr,
	output logic [IDX_W-1:0]  cursor_position
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int BOTTOM = CELLS - COLUMNS;
	localparam int AW     = $clog2(CELLS);

	tcw_state_t        state_q, state_d;
	logic [AW-1:0]     cp_q, cp_d;
	logic              done_q, done_d;
	logic [CHAR_W-1:0] cell_char_q, cell_char_d;
	logic [CHAR_W-1:0] cell_attr_q, cell_attr_d;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic [AW-1:0]     raddr;
	logic [CELL_W-1:0] rdata;

	cur_cmd_t          cur_cmd;
	cur_stat_t         cur_stat;
	logic [AW-1:0]     cursor;
	logic              accept;

	assign accept = start && (state_q == ST_IDLE);

	tcw_screen_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	tcw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS),
		.AW     (AW)
	) u_cursor (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cur_cmd),
		.cursor(cursor),
		.stat  (cur_stat)
	);

	always_comb begin
		state_d     = state_q;
		cp_d        = cp_q;
		done_d      = 1'b0;
		cell_char_d = '0;
		cell_attr_d = '0;
		we          = 1'b0;
		waddr       = cp_q;
		wdata       = '0;
		raddr       = AW'(cell_index);
		cur_cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				if (cp_q == AW'(CELLS - 1)) begin
					cp_d    = '0;
					state_d = ST_IDLE;
				end else begin
					cp_d = cp_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_READ) begin
						if (32'(cell_index) < CELLS) begin
							state_d = ST_READ;
						end else begin
							done_d = 1'b1;
						end
					end else if (char_code == CH_NUL) begin
						done_d = 1'b1;
					end else if (char_code == CH_LF || char_code == CH_CR) begin
						if (cur_stat.bottom_row) begin
							cp_d    = '0;
							state_d = ST_COPY;
						end else begin
							cur_cmd.newline = 1'b1;
							done_d          = 1'b1;
						end
					end else begin
						we    = 1'b1;
						waddr = cursor;
						wdata = {PLAIN_ATTR, char_code};
						if (cur_stat.last_cell) begin
							cp_d    = '0;
							state_d = ST_COPY;
						end else begin
							cur_cmd.advance = 1'b1;
							done_d          = 1'b1;
						end
					end
				end
			end
			ST_READ: begin
				cell_char_d = rdata[CHAR_W-1:0];
				cell_attr_d = rdata[CELL_W-1:CHAR_W];
				done_d      = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_COPY: begin
				// Read one row ahead and write back the cell read in the previous cycle.
				raddr = cp_q + AW'(COLUMNS);
				we    = (cp_q != '0);
				waddr = cp_q - 1'b1;
				wdata = rdata;
				if (cp_q == AW'(BOTTOM)) begin
					state_d = ST_FILL;
				end else begin
					cp_d = cp_q + 1'b1;
				end
			end
			ST_FILL: begin
				we = 1'b1;
				if (cp_q == AW'(BOTTOM)) begin
					wdata = {PLAIN_ATTR, CH_NUL};
				end
				if (cp_q == AW'(CELLS - 1)) begin
					cp_d              = '0;
					cur_cmd.to_bottom = 1'b1;
					done_d            = 1'b1;
					state_d           = ST_IDLE;
				end else begin
					cp_d = cp_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cp_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cp_q    <= cp_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cell_char_q <= cell_char_d;
		cell_attr_q <= cell_attr_d;
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign cell_char       = cell_char_q;
	assign cell_attr       = cell_attr_q;
	assign cursor_position = IDX_W'(cursor);

	// A result is only ever shown once the sequencer is back in idle.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// Every accepted command either finishes at once or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted command dropped");

	// The cursor never leaves the screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cursor) < CELLS)
		else $error("cursor out of range");

	// The scroll sweep ends with the cursor at the start of the bottom row.
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && cp_q == AW'(CELLS - 1)) |=> (32'(cursor) == BOTTOM))
		else $error("cursor not on bottom row after scroll");

endmodule
